[design/counted_blink_sequencer_core_macros.svh]
// Assertion helpers for the blink sequencer.
`ifndef COUNTED_BLINK_SEQUENCER_CORE_MACROS_SVH
`define COUNTED_BLINK_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define CBS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held.
`define CBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/cbs_pkg.sv]
package cbs_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int COUNT_W        = 8;
    localparam int TICKS_IN_W     = 32;

    typedef enum logic [2:0] {
        MODE_TICK   = 3'd0,
        MODE_START  = 3'd1,
        MODE_ON     = 3'd2,
        MODE_OFF    = 3'd3,
        MODE_TOGGLE = 3'd4
    } t_mode;

    typedef struct packed {
        t_mode                  mode;
        logic [COUNT_W-1:0]     blink_count;
        logic [TICKS_IN_W-1:0]  on_ticks;
        logic [TICKS_IN_W-1:0]  off_ticks;
    } t_item;

    // Sequencer state as reported in a result.
    typedef struct packed {
        logic               lit;
        logic [COUNT_W-1:0] blinks_remaining;
        logic               timer_running;
    } t_status;

endpackage

[design/cbs_in_stage.sv]
module cbs_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cbs_pkg::t_item i_item,
    input  logic           i_advance,
    output logic           o_stall,
    output logic           o_valid,
    output cbs_pkg::t_item o_item
);
    import cbs_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_accept;

    // Holding register frees up in the same cycle it hands off.
    assign o_stall  = r_valid && !i_advance;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[design/cbs_engine.sv]
module cbs_engine #(
    parameter int TIME_WIDTH = cbs_pkg::TIME_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  cbs_pkg::t_item   i_item,
    output cbs_pkg::t_status o_status
);
    import cbs_pkg::*;
    `include "counted_blink_sequencer_core_macros.svh"

    localparam logic [TIME_WIDTH-1:0] TicksOne = TIME_WIDTH'(1);

    logic                  r_lit,      n_lit;
    logic [COUNT_W-1:0]    r_blinks,   n_blinks;
    logic [TIME_WIDTH-1:0] r_ticks,    n_ticks;
    logic                  r_timer_en, n_timer_en;
    logic [TIME_WIDTH-1:0] r_on,       n_on;
    logic [TIME_WIDTH-1:0] r_off,      n_off;
    logic [TIME_WIDTH-1:0] w_on_in;
    logic [TIME_WIDTH-1:0] w_off_in;

    // Times fit to the timer width (truncate or zero-extend).
    assign w_on_in  = TIME_WIDTH'(i_item.on_ticks);
    assign w_off_in = TIME_WIDTH'(i_item.off_ticks);

    always_comb begin
        n_lit      = r_lit;
        n_blinks   = r_blinks;
        n_ticks    = r_ticks;
        n_timer_en = r_timer_en;
        n_on       = r_on;
        n_off      = r_off;
        case (i_item.mode)
            MODE_TICK: begin
                if (r_timer_en) begin
                    if (r_ticks > TicksOne) begin
                        n_ticks = r_ticks - TicksOne;
                    end else begin
                        // phase expired
                        n_ticks = '0;
                        if (r_lit) begin
                            if (r_off != '0) begin
                                n_ticks    = r_off;
                                n_timer_en = 1'b1;
                            end else begin
                                n_timer_en = 1'b0;
                            end
                            n_lit = 1'b0;
                        end else if (r_blinks != COUNT_W'(1)) begin
                            // zero count is endless
                            if (r_blinks != '0) begin
                                n_blinks = r_blinks - COUNT_W'(1);
                            end
                            n_ticks    = r_on;
                            n_timer_en = 1'b1;
                            n_lit      = 1'b1;
                        end else begin
                            n_blinks   = '0;
                            n_timer_en = 1'b0;
                        end
                    end
                end
            end
            MODE_START: begin
                n_blinks   = i_item.blink_count;
                n_on       = w_on_in;
                n_off      = w_off_in;
                n_ticks    = w_on_in;
                n_timer_en = 1'b1;
                n_lit      = 1'b1;
            end
            MODE_ON: begin
                n_blinks   = '0;
                n_timer_en = 1'b0;
                n_lit      = 1'b1;
            end
            MODE_OFF: begin
                n_blinks   = '0;
                n_timer_en = 1'b0;
                n_lit      = 1'b0;
            end
            MODE_TOGGLE: begin
                n_blinks   = '0;
                n_timer_en = 1'b0;
                n_lit      = !r_lit;
            end
            default: begin
                // unused modes leave state alone
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit      <= 1'b0;
            r_blinks   <= '0;
            r_ticks    <= '0;
            r_timer_en <= 1'b0;
            r_on       <= '0;
            r_off      <= '0;
        end else if (i_fire) begin
            r_lit      <= n_lit;
            r_blinks   <= n_blinks;
            r_ticks    <= n_ticks;
            r_timer_en <= n_timer_en;
            r_on       <= n_on;
            r_off      <= n_off;
        end
    end

    assign o_status.lit              = n_lit;
    assign o_status.blinks_remaining = n_blinks;
    assign o_status.timer_running    = n_timer_en;

    `CBS_ASSERT_NEXT(a_hold_when_idle, i_clk, i_rst_n, !i_fire,
        $stable(r_lit) && $stable(r_blinks) && $stable(r_timer_en) && $stable(r_ticks),
        "sequencer state moved without a transaction")
    `CBS_ASSERT_NEXT(a_start_lights, i_clk, i_rst_n, i_fire && i_item.mode == MODE_START,
        r_lit && r_timer_en && r_ticks == r_on,
        "blink start did not light and load the on time")
    `CBS_ASSERT_NEXT(a_force_cancels, i_clk, i_rst_n,
        i_fire && (i_item.mode == MODE_ON || i_item.mode == MODE_OFF
                   || i_item.mode == MODE_TOGGLE),
        !r_timer_en && r_blinks == '0,
        "forced level left blinking active")
    `CBS_ASSERT_NEXT(a_idle_tick, i_clk, i_rst_n,
        i_fire && i_item.mode == MODE_TICK && !r_timer_en,
        $stable(r_lit) && $stable(r_blinks) && !r_timer_en,
        "tick with stopped timer changed state")

endmodule

[design/counted_blink_sequencer_core.sv]
// Channel   Direction  Handshake                    Payload
// -------   ---------  ---------------------------  ----------------------------------------
// in        to core    i_in_valid / o_in_stall      i_mode, i_blink_count, i_on_ticks,
//                                                   i_off_ticks
// out       from core  o_out_valid / i_out_stall    o_pin_level, o_lit, o_blinks_remaining,
//                                                   o_timer_running
// cfg       to core    i_cfg_we                     i_cfg_wdata (active_level)
//
// One transaction in, one result out, at one transaction per cycle sustained while the
// output is not stalled. Each item passes the input register, then the state update
// into the result register. The state update (timer decrement / phase change) is
// combinational logic, so items can follow back to back while the result register
// is being drained. A stall on the output holds the result; once the input register is
// also full, o_in_stall follows i_out_stall in the same cycle (combinational path).
// Reset (i_rst_n low, synchronous) empties both stages, clears the sequencer to dark,
// timer stopped, and sets active_level to 1.
module counted_blink_sequencer_core #(
    parameter int TIME_WIDTH = cbs_pkg::TIME_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [2:0]                    i_mode,
    input  logic [cbs_pkg::COUNT_W-1:0]   i_blink_count,
    input  logic [cbs_pkg::TICKS_IN_W-1:0] i_on_ticks,
    input  logic [cbs_pkg::TICKS_IN_W-1:0] i_off_ticks,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_pin_level,
    output logic                          o_lit,
    output logic [cbs_pkg::COUNT_W-1:0]   o_blinks_remaining,
    output logic                          o_timer_running,
    // configuration
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata
);
    import cbs_pkg::*;

    t_item   w_in_item;
    t_item   w_held_item;
    logic    w_held_valid;
    logic    w_advance;
    t_status w_next_status;

    logic    r_active_level;
    logic    r_out_valid, n_out_valid;
    t_status r_out_status;

    assign w_in_item.mode        = t_mode'(i_mode);
    assign w_in_item.blink_count = i_blink_count;
    assign w_in_item.on_ticks    = i_on_ticks;
    assign w_in_item.off_ticks   = i_off_ticks;

    // Held item moves on whenever the result register is empty or being taken.
    assign w_advance = w_held_valid && (!r_out_valid || !i_out_stall);

    cbs_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_stall   (o_in_stall),
        .o_valid   (w_held_valid),
        .o_item    (w_held_item)
    );

    cbs_engine #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_advance),
        .i_item   (w_held_item),
        .o_status (w_next_status)
    );

    // active_level register; the user must change it only while the core is idle (not enforced)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level <= 1'b1;
        end else if (i_cfg_we) begin
            r_active_level <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_status <= w_next_status;
        end
    end

    assign o_out_valid        = r_out_valid;
    // lit drives active_level, dark drives its complement
    assign o_pin_level        = !(r_out_status.lit ^ r_active_level);
    assign o_lit              = r_out_status.lit;
    assign o_blinks_remaining = r_out_status.blinks_remaining;
    assign o_timer_running    = r_out_status.timer_running;

endmodule
